>>> design/dqbe_pkg.sv
// ----------------------------------------------------------------------------
// dqbe_pkg
// Shared types, constants and character functions for the DNS query
// base64url text encoder.
// ----------------------------------------------------------------------------
package dqbe_pkg;

    // label buffer sizing
    localparam int LABEL_MAX = 63;
    localparam int FILL_W    = $clog2(LABEL_MAX + 1);
    localparam int ADDR_W    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam int CNT_W     = (FILL_W > 3) ? FILL_W : 3;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CLASS = 1'b1;

    // characters and masks
    localparam logic [7:0] DOT_CHAR      = 8'h2E;
    localparam logic [7:0] LEN_MASK      = 8'h3F;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
    localparam logic [7:0] CHAR_DASH     = 8'h2D;
    localparam logic [7:0] CHAR_USCORE   = 8'h5F;

    // header text quads: flags word carries the recursion bit, one question
    localparam logic [31:0] HDR_QUAD_ONE  = 32'h4141_4142;
    localparam logic [31:0] HDR_QUAD_ZERO = 32'h4141_4141;
    localparam logic [1:0]  HDR_LAST_IDX  = 2'd3;

    // trailer byte sequence: zero byte, type word, class word
    localparam logic [2:0] TAIL_ZERO    = 3'd0;
    localparam logic [2:0] TAIL_TYPE_HI = 3'd1;
    localparam logic [2:0] TAIL_TYPE_LO = 3'd2;
    localparam logic [2:0] TAIL_CLS_HI  = 3'd3;
    localparam logic [2:0] TAIL_CLS_LO  = 3'd4;

    // character counts of a quad
    localparam logic [2:0] QCOUNT_FULL  = 3'd4;
    localparam logic [2:0] QCOUNT_THREE = 3'd3;
    localparam logic [2:0] QCOUNT_TWO   = 3'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN,
        ST_BYTES,
        ST_TAIL,
        ST_PART,
        ST_LAST
    } dqbe_state_t;

    // byte source for the packing register
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_LEN,
        SRC_STORE,
        SRC_TAIL
    } dqbe_src_t;

    // controller to datapath commands
    typedef struct packed {
        logic      accept;
        logic      hdr_emit;
        dqbe_src_t push_src;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      rd_en;
        logic      rd_first;
        logic      fill_clr;
        logic      part_emit;
        logic      finish_clr;
        logic      send_last;
    } dqbe_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic header_sent;
        logic is_dot;
        logic is_final;
        logic fill_zero;
        logic byte_last;
        logic hdr_last;
        logic tail_last;
        logic res_ok;
        logic push_ok;
        logic carry_zero;
        logic pend_valid;
        logic out_free;
    } dqbe_status_t;

    // base64url alphabet lookup
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
        begin
            c = CHAR_UPPER_A + 8'(v);
        end
        else if (v < 6'd52)
        begin
            c = CHAR_LOWER_A + 8'(v - 6'd26);
        end
        else if (v < 6'd62)
        begin
            c = CHAR_DIGIT_0 + 8'(v - 6'd52);
        end
        else if (v == 6'd62)
        begin
            c = CHAR_DASH;
        end
        else
        begin
            c = CHAR_USCORE;
        end
        return c;
    endfunction

    // fixed header text, four quads
    function automatic logic [31:0] header_quad(input logic [1:0] h);
        return (h < 2'd2) ? HDR_QUAD_ONE : HDR_QUAD_ZERO;
    endfunction

endpackage

>>> design/dqbe_ctrl.sv
// ----------------------------------------------------------------------------
// dqbe_ctrl
// Sequencer for one name character: header, label flush, trailer, partial
// group and the final result hand-off.
// ----------------------------------------------------------------------------
module dqbe_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dqbe_pkg::dqbe_status_t status,
    output dqbe_pkg::dqbe_cmd_t    cmd
);
    import dqbe_pkg::*;

    dqbe_state_t state_reg;
    dqbe_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (status.header_sent)
                begin
                    if (status.is_dot || status.is_final)
                    begin
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (status.res_ok && status.hdr_last)
                begin
                    state_next = (status.is_dot || status.is_final) ? ST_LEN : ST_LAST;
                end
            end
            ST_LEN:
            begin
                if (status.push_ok)
                begin
                    if (!status.fill_zero)
                    begin
                        state_next = ST_BYTES;
                    end
                    else
                    begin
                        state_next = status.is_final ? ST_TAIL : ST_LAST;
                    end
                end
            end
            ST_BYTES:
            begin
                if (status.push_ok && status.byte_last)
                begin
                    state_next = status.is_final ? ST_TAIL : ST_LAST;
                end
            end
            ST_TAIL:
            begin
                if (status.push_ok && status.tail_last)
                begin
                    state_next = ST_PART;
                end
            end
            ST_PART:
            begin
                if (status.carry_zero || status.res_ok)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        cmd.push_src = SRC_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                end
            end
            ST_HDR:
            begin
                if (!status.header_sent && status.res_ok)
                begin
                    cmd.hdr_emit = 1'b1;
                    if (status.hdr_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                // prefetch the first label byte while the length goes out
                cmd.rd_en    = !status.fill_zero;
                cmd.rd_first = 1'b1;
                if (status.push_ok)
                begin
                    cmd.push_src = SRC_LEN;
                    cmd.cnt_clr  = 1'b1;
                    cmd.fill_clr = status.fill_zero;
                end
            end
            ST_BYTES:
            begin
                if (status.push_ok)
                begin
                    cmd.push_src = SRC_STORE;
                    if (status.byte_last)
                    begin
                        cmd.fill_clr = 1'b1;
                        cmd.cnt_clr  = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                    end
                end
            end
            ST_TAIL:
            begin
                if (status.push_ok)
                begin
                    cmd.push_src = SRC_TAIL;
                    if (status.tail_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_PART:
            begin
                if (status.carry_zero || status.res_ok)
                begin
                    cmd.part_emit  = 1'b1;
                    cmd.finish_clr = 1'b1;
                end
            end
            ST_LAST:
            begin
                cmd.send_last = status.pend_valid && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/dqbe_datapath.sv
// ----------------------------------------------------------------------------
// dqbe_datapath
// Label store, byte packing into base64url quads, pending result stage and
// output register.
// ----------------------------------------------------------------------------
module dqbe_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dqbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dqbe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                        name_char,
    input  logic                              final_char,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [31:0]                       text_quad,
    output logic [2:0]                        quad_count,
    output logic                              run_end,
    output logic                              query_end,
    output logic                              label_overflow,
    input  dqbe_pkg::dqbe_cmd_t               cmd,
    output dqbe_pkg::dqbe_status_t            status
);
    import dqbe_pkg::*;

    logic [CFG_DATA_W-1:0] qtype_reg;
    logic [CFG_DATA_W-1:0] qclass_reg;

    logic [7:0]        store_mem [LABEL_MAX];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [FILL_W-1:0] fill_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_plus;
    logic [15:0]       carry_bytes_reg;
    logic [1:0]        carry_cnt_reg;
    logic              header_sent_reg;
    logic              overflow_reg;
    logic              dot_reg;
    logic              fin_reg;

    logic [7:0]        push_byte;
    logic              push_fire;
    logic [23:0]       full_word;
    logic [23:0]       part_word;

    logic              new_valid;
    logic [31:0]       new_quad;
    logic [2:0]        new_count;
    logic              new_qend;

    logic              p_valid_reg;
    logic [31:0]       p_quad_reg;
    logic [2:0]        p_count_reg;
    logic              p_qend_reg;
    logic              p_ovf_reg;

    logic              out_valid_reg;
    logic [31:0]       text_quad_reg;
    logic [2:0]        quad_count_reg;
    logic              run_end_reg;
    logic              query_end_reg;
    logic              label_overflow_reg;

    logic              out_free;
    logic              res_ok;
    logic              load_out;
    logic              char_is_dot;
    logic              fill_room;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qtype_reg  <= CFG_DATA_W'(1);
            qclass_reg <= CFG_DATA_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_QUERY_TYPE:  qtype_reg  <= cfg_data;
                CFG_QUERY_CLASS: qclass_reg <= cfg_data;
                default:         qtype_reg  <= qtype_reg;
            endcase
        end
    end

    assign char_is_dot = (name_char == DOT_CHAR);
    assign fill_room   = (fill_reg < FILL_W'(LABEL_MAX));
    assign cnt_plus    = cnt_reg + 1'b1;
    assign rd_addr     = cmd.rd_first ? '0 : cnt_plus[ADDR_W-1:0];

    // label store write on accepted non-dot characters while the store has room
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !char_is_dot && fill_room)
        begin
            store_mem[fill_reg[ADDR_W-1:0]] <= name_char;
        end
    end

    // label store registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // byte source selection
    always_comb
    begin
        push_byte = 8'h00;
        unique case (cmd.push_src)
            SRC_LEN:   push_byte = 8'(fill_reg) & LEN_MASK;
            SRC_STORE: push_byte = rd_data_reg;
            SRC_TAIL:
            begin
                unique case (cnt_reg[2:0])
                    TAIL_ZERO:    push_byte = 8'h00;
                    TAIL_TYPE_HI: push_byte = qtype_reg[15:8];
                    TAIL_TYPE_LO: push_byte = qtype_reg[7:0];
                    TAIL_CLS_HI:  push_byte = qclass_reg[15:8];
                    TAIL_CLS_LO:  push_byte = qclass_reg[7:0];
                    default:      push_byte = 8'h00;
                endcase
            end
            default:   push_byte = 8'h00;
        endcase
    end

    assign push_fire = (cmd.push_src != SRC_NONE);
    assign full_word = {carry_bytes_reg, push_byte};
    assign part_word = (carry_cnt_reg == 2'd1) ? {carry_bytes_reg[7:0], 16'h0000}
                                               : {carry_bytes_reg, 8'h00};

    // new result from header, full group or final partial group
    always_comb
    begin
        new_valid = 1'b0;
        new_quad  = 32'h0;
        new_count = QCOUNT_FULL;
        new_qend  = 1'b0;
        if (cmd.hdr_emit)
        begin
            new_valid = 1'b1;
            new_quad  = header_quad(cnt_reg[1:0]);
        end
        else if (push_fire && (carry_cnt_reg == 2'd2))
        begin
            new_valid = 1'b1;
            new_quad  = {b64_char(full_word[23:18]), b64_char(full_word[17:12]),
                         b64_char(full_word[11:6]), b64_char(full_word[5:0])};
        end
        else if (cmd.part_emit && (carry_cnt_reg != 2'd0))
        begin
            new_valid = 1'b1;
            new_qend  = 1'b1;
            new_count = (carry_cnt_reg == 2'd1) ? QCOUNT_TWO : QCOUNT_THREE;
            new_quad  = {b64_char(part_word[23:18]), b64_char(part_word[17:12]),
                         (carry_cnt_reg == 2'd2) ? b64_char(part_word[11:6]) : 8'h00,
                         8'h00};
        end
    end

    // per-name control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            cnt_reg         <= '0;
            carry_bytes_reg <= 16'h0000;
            carry_cnt_reg   <= 2'd0;
            header_sent_reg <= 1'b0;
            overflow_reg    <= 1'b0;
            dot_reg         <= 1'b0;
            fin_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                dot_reg <= char_is_dot;
                fin_reg <= final_char;
                if (!char_is_dot)
                begin
                    if (fill_room)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_reg <= 1'b1;
                    end
                end
            end
            else if (cmd.fill_clr)
            begin
                fill_reg <= '0;
            end

            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_plus;
            end

            if (cmd.hdr_emit && (cnt_reg[1:0] == HDR_LAST_IDX))
            begin
                header_sent_reg <= 1'b1;
            end

            // three-byte packing register
            if (cmd.finish_clr)
            begin
                carry_bytes_reg <= 16'h0000;
                carry_cnt_reg   <= 2'd0;
                header_sent_reg <= 1'b0;
                overflow_reg    <= 1'b0;
            end
            else if (push_fire)
            begin
                if (carry_cnt_reg != 2'd2)
                begin
                    carry_bytes_reg <= {carry_bytes_reg[7:0], push_byte};
                    carry_cnt_reg   <= carry_cnt_reg + 2'd1;
                end
                else
                begin
                    carry_bytes_reg <= 16'h0000;
                    carry_cnt_reg   <= 2'd0;
                end
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign res_ok   = !p_valid_reg || out_free;
    assign load_out = (new_valid && p_valid_reg) || cmd.send_last;

    // pending and output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (new_valid)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (cmd.send_last)
            begin
                p_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pending result and output payload
    always_ff @(posedge clk)
    begin
        if (new_valid)
        begin
            p_quad_reg  <= new_quad;
            p_count_reg <= new_count;
            p_qend_reg  <= new_qend;
            p_ovf_reg   <= overflow_reg;
        end
        else if (cmd.part_emit && (carry_cnt_reg == 2'd0))
        begin
            p_qend_reg <= 1'b1;
        end

        if (load_out)
        begin
            text_quad_reg      <= p_quad_reg;
            quad_count_reg     <= p_count_reg;
            query_end_reg      <= p_qend_reg;
            label_overflow_reg <= p_ovf_reg;
            run_end_reg        <= cmd.send_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign text_quad      = text_quad_reg;
    assign quad_count     = quad_count_reg;
    assign run_end        = run_end_reg;
    assign query_end      = query_end_reg;
    assign label_overflow = label_overflow_reg;

    // status to the controller
    always_comb
    begin
        status.header_sent = header_sent_reg;
        status.is_dot      = dot_reg;
        status.is_final    = fin_reg;
        status.fill_zero   = (fill_reg == '0);
        status.byte_last   = (cnt_plus == CNT_W'(fill_reg));
        status.hdr_last    = (cnt_reg[1:0] == HDR_LAST_IDX);
        status.tail_last   = (cnt_reg[2:0] == TAIL_CLS_LO);
        status.res_ok      = res_ok;
        status.push_ok     = (carry_cnt_reg != 2'd2) || res_ok;
        status.carry_zero  = (carry_cnt_reg == 2'd0);
        status.pend_valid  = p_valid_reg;
        status.out_free    = out_free;
    end

endmodule

>>> design/dns_query_base64url_encoder_top.sv
// ----------------------------------------------------------------------------
// dns_query_base64url_encoder_top
// Turns a domain name, one character per transfer, into the base64url text
// of a DNS query, up to four characters per output transfer.
// ----------------------------------------------------------------------------
// Input channel: name_char/final_char with in_valid/in_ready; final_char marks
// the last character of a name. Output channel: text_quad, quad_count,
// run_end, query_end, label_overflow with out_valid/out_ready. Query type and
// class come from the write port (index 0 and 1, reset value 1 each).
// One character is handled at a time. A character that only goes into the
// label buffer passes the header state and returns to idle; when it opens a
// name, the four header quads go out first, then a hand-off. An opening dot
// or final character goes on from the header to the label flush. A dot
// sends the length byte, then each label byte, fed from the label memory
// with a prefetch into the three-byte packing register, and ends with the
// last hand-off. A final character also sends 5 trailer bytes and the
// partial group. The last result of a transfer is held back one stage so
// that run_end can be marked.
// Reset clears all per-name state and sets both words to 1; the label memory
// is not cleared. When the receiver stalls, the output register and the
// pending stage hold and the sequencer waits; no input is taken until the
// current character's results have all left the pending stage.
// ----------------------------------------------------------------------------
module dns_query_base64url_encoder_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dqbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dqbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       name_char,
    input  logic                             final_char,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [31:0]                      text_quad,
    output logic [2:0]                       quad_count,
    output logic                             run_end,
    output logic                             query_end,
    output logic                             label_overflow
);
    import dqbe_pkg::*;

    dqbe_cmd_t    cmd;
    dqbe_status_t status;

    // sequencer
    dqbe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // label store, packing and output stages
    dqbe_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .name_char      (name_char),
        .final_char     (final_char),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .text_quad      (text_quad),
        .quad_count     (quad_count),
        .run_end        (run_end),
        .query_end      (query_end),
        .label_overflow (label_overflow),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

>>> design/dqbe_checker.sv
// ----------------------------------------------------------------------------
// dqbe_checker
// Port-level checks of the DNS query base64url encoder, bound to the top.
// ----------------------------------------------------------------------------
module dqbe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] text_quad,
    input logic [2:0]  quad_count,
    input logic        run_end,
    input logic        query_end
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(text_quad) && $stable(quad_count))
        else $error("output changed while stalled");

    // short quads only close a query
    a_short_quad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quad_count == 3'd4) ||
                      ((quad_count == 3'd2 || quad_count == 3'd3) && query_end))
        else $error("bad character count");

    // end of query is always the last result of its transfer
    a_qend_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && query_end |-> run_end)
        else $error("query end without run end");

    // unused low byte of a short quad is zero
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && quad_count != 3'd4 |-> text_quad[7:0] == 8'h00)
        else $error("short quad low byte not zero");

    // one character at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind dns_query_base64url_encoder_top dqbe_checker u_dqbe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .text_quad  (text_quad),
    .quad_count (quad_count),
    .run_end    (run_end),
    .query_end  (query_end)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DNS query base64url text encoder. Domain names
// go in one character per transfer. A scoreboard class keeps its own model of
// the header, label packing and trailer, and checks every output quad field
// by field. Runs cover directed corner names, random and noisy names, label
// overflow, several type/class settings, random idling on both channels and
// one long receiver hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [31:0] quad;
    logic [2:0]  count;
    logic        run_end;
    logic        query_end;
    logic        overflow;
} text_quad_t;

class query_text_scoreboard;
    logic [7:0]  label_buf [dqbe_pkg::LABEL_MAX];
    int          label_len;
    logic [15:0] carry;
    int          carry_n;
    bit          header_done;
    bit          overflow;
    logic [15:0] qtype;
    logic [15:0] qclass;
    text_quad_t  text_due [$];
    text_quad_t  step_text [$];
    int          errors;

    function new();
        label_len   = 0;
        carry       = 16'h0;
        carry_n     = 0;
        header_done = 1'b0;
        overflow    = 1'b0;
        qtype       = 16'h0001;
        qclass      = 16'h0001;
        errors      = 0;
    endfunction

    function void set_word(logic [dqbe_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        if (idx == dqbe_pkg::CFG_QUERY_TYPE)
        begin
            qtype = value;
        end
        else if (idx == dqbe_pkg::CFG_QUERY_CLASS)
        begin
            qclass = value;
        end
    endfunction

    function int pending();
        return text_due.size();
    endfunction

    // url-safe alphabet
    function logic [7:0] b64(logic [5:0] v);
        string alpha;
        alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
        return alpha[v];
    endfunction

    function void add_quad(logic [31:0] q, logic [2:0] n, bit last);
        text_quad_t r;
        r.quad      = q;
        r.count     = n;
        r.run_end   = 1'b0;
        r.query_end = last;
        r.overflow  = overflow;
        step_text.push_back(r);
    endfunction

    // three bytes make one full quad
    function void pack_byte(logic [7:0] b);
        logic [23:0] w;
        if (carry_n < 2)
        begin
            carry = {carry[7:0], b};
            carry_n++;
        end
        else
        begin
            w = {carry, b};
            add_quad({b64(w[23:18]), b64(w[17:12]), b64(w[11:6]), b64(w[5:0])}, 3'd4, 1'b0);
            carry   = 16'h0;
            carry_n = 0;
        end
    endfunction

    function void flush_label();
        pack_byte({2'b00, 6'(label_len)});
        for (int k = 0; k < label_len; k++)
        begin
            pack_byte(label_buf[k]);
        end
        label_len = 0;
    endfunction

    // zero byte, type, class, then the unpadded tail group
    function void close_query();
        text_quad_t r;
        pack_byte(8'h00);
        pack_byte(qtype[15:8]);
        pack_byte(qtype[7:0]);
        pack_byte(qclass[15:8]);
        pack_byte(qclass[7:0]);
        if (carry_n == 1)
        begin
            add_quad({b64(carry[7:2]), b64({carry[1:0], 4'b0000}), 16'h0000}, 3'd2, 1'b1);
        end
        else if (carry_n == 2)
        begin
            add_quad({b64(carry[15:10]), b64(carry[9:4]), b64({carry[3:0], 2'b00}), 8'h00},
                     3'd3, 1'b1);
        end
        else
        begin
            r = step_text.pop_back();
            r.query_end = 1'b1;
            step_text.push_back(r);
        end
        carry       = 16'h0;
        carry_n     = 0;
        label_len   = 0;
        header_done = 1'b0;
        overflow    = 1'b0;
    endfunction

    // work out the quads caused by one accepted character
    function void take_char(logic [7:0] c, logic fin);
        string      hdr;
        text_quad_t r;
        hdr = "AAABAAABAAAAAAAA";
        step_text.delete();
        if (!header_done)
        begin
            for (int h = 0; h < 4; h++)
            begin
                add_quad({hdr[4*h], hdr[4*h+1], hdr[4*h+2], hdr[4*h+3]}, 3'd4, 1'b0);
            end
            header_done = 1'b1;
        end
        if (c == dqbe_pkg::DOT_CHAR)
        begin
            flush_label();
        end
        else if (label_len < dqbe_pkg::LABEL_MAX)
        begin
            label_buf[label_len] = c;
            label_len++;
        end
        else
        begin
            overflow = 1'b1;
        end
        if (fin)
        begin
            if (c != dqbe_pkg::DOT_CHAR)
            begin
                flush_label();
            end
            close_query();
        end
        if (step_text.size() > 0)
        begin
            r = step_text.pop_back();
            r.run_end = 1'b1;
            step_text.push_back(r);
        end
        foreach (step_text[i])
        begin
            text_due.push_back(step_text[i]);
        end
    endfunction

    function void check_quad(logic [31:0] q, logic [2:0] n, logic re, logic qe, logic ov);
        text_quad_t w;
        if (text_due.size() == 0)
        begin
            $display("%0t: unexpected quad %h count %0d", $time, q, n);
            errors++;
            return;
        end
        w = text_due.pop_front();
        if (w.quad !== q)
        begin
            $display("%0t: text_quad expected %h actual %h", $time, w.quad, q);
            errors++;
        end
        if (w.count !== n)
        begin
            $display("%0t: quad_count expected %0d actual %0d", $time, w.count, n);
            errors++;
        end
        if (w.run_end !== re)
        begin
            $display("%0t: run_end expected %b actual %b", $time, w.run_end, re);
            errors++;
        end
        if (w.query_end !== qe)
        begin
            $display("%0t: query_end expected %b actual %b", $time, w.query_end, qe);
            errors++;
        end
        if (w.overflow !== ov)
        begin
            $display("%0t: label_overflow expected %b actual %b", $time, w.overflow, ov);
            errors++;
        end
    endfunction
endclass

module tb;
    import dqbe_pkg::*;

    localparam int WATCHDOG  = 5000;
    localparam int SETTLE    = 16;
    localparam int LONG_HOLD = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            name_char;
    logic                  final_char;
    logic                  out_valid;
    logic                  out_ready;
    logic [31:0]           text_quad;
    logic [2:0]            quad_count;
    logic                  run_end;
    logic                  query_end;
    logic                  label_overflow;

    query_text_scoreboard board;
    int quiet_cycles = 0;
    int sent = 0;
    int start;
    bit src_gaps;
    bit sink_gaps;
    bit vary_idle;
    bit hold_req;

    dns_query_base64url_encoder_top uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .name_char      (name_char),
        .final_char     (final_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .text_quad      (text_quad),
        .quad_count     (quad_count),
        .run_end        (run_end),
        .query_end      (query_end),
        .label_overflow (label_overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall bursts and one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            board.take_char(name_char, final_char);
        end
        if (out_valid && out_ready)
        begin
            board.check_quad(text_quad, quad_count, run_end, query_end, label_overflow);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG)
        begin
            $display("%0t: no transfer for %0d cycles, %0d quads outstanding",
                     $time, WATCHDOG, board.pending());
            $display("tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one character transfer, with an optional gap before it
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = (src_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        name_char  <= c;
        final_char <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sent++;
    endtask

    // one domain name; the first label may be forced to a given length
    task automatic send_name(input int big, input bit noisy);
        logic [7:0] txt [$];
        logic [7:0] c;
        int         nl;
        int         len;
        if (vary_idle)
        begin
            src_gaps  = $urandom_range(0, 2) != 0;
            sink_gaps = $urandom_range(0, 2) != 0;
        end
        nl = $urandom_range(1, 4);
        for (int l = 0; l < nl; l++)
        begin
            if (l > 0)
            begin
                txt.push_back(DOT_CHAR);
            end
            len = (l == 0 && big > 0) ? big : $urandom_range(0, 9);
            repeat (len)
            begin
                if (noisy && $urandom_range(0, 4) == 0)
                begin
                    c = DOT_CHAR;
                end
                else
                begin
                    do
                    begin
                        c = 8'($urandom_range(0, 255));
                    end
                    while (c == DOT_CHAR);
                end
                txt.push_back(c);
            end
        end
        // trailing dot now and then
        if (txt.size() == 0 || $urandom_range(0, 3) == 0)
        begin
            txt.push_back(DOT_CHAR);
        end
        foreach (txt[i])
        begin
            send_char(txt[i], i == txt.size() - 1);
        end
    endtask

    // drop valid, wait for every quad, then let the pipeline go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_word(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_word(idx, value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        board      = new();
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_QUERY_TYPE;
        cfg_data   = 16'h0000;
        in_valid   = 1'b0;
        name_char  = 8'h00;
        final_char = 1'b0;
        hold_req   = 1'b0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;
        vary_idle  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed names at reset type and class
        send_char(DOT_CHAR, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char("x", 1'b0);
        send_char("y", 1'b1);
        // empty label inside the name, then a trailing dot
        send_char("a", 1'b0);
        send_char(DOT_CHAR, 1'b0);
        send_char(DOT_CHAR, 1'b0);
        send_char("b", 1'b0);
        send_char(DOT_CHAR, 1'b1);
        // leading dot
        send_char(DOT_CHAR, 1'b0);
        send_char("q", 1'b1);
        send_char("w", 1'b0);
        send_char("w", 1'b0);
        send_char("w", 1'b0);
        send_char(DOT_CHAR, 1'b0);
        send_char("7", 1'b1);
        settle();

        // random names, all-ones type and zero class
        program_word(CFG_QUERY_TYPE, 16'hFFFF);
        program_word(CFG_QUERY_CLASS, 16'h0000);
        vary_idle = 1'b1;
        start = sent;
        while (sent - start < 20)
        begin
            send_name(0, $urandom_range(0, 3) == 0);
        end
        settle();

        // full-size label, then an overflowing one behind a long receiver hold-off
        program_word(CFG_QUERY_TYPE, 16'h0000);
        program_word(CFG_QUERY_CLASS, 16'hFFFF);
        send_name(LABEL_MAX, 1'b0);
        hold_req = 1'b1;
        send_name(LABEL_MAX + 3, 1'b0);
        start = sent;
        while (sent - start < 10)
        begin
            send_name(0, $urandom_range(0, 3) == 0);
        end
        settle();

        // random words, no idling on either side
        program_word(CFG_QUERY_TYPE, 16'($urandom_range(0, 65535)));
        program_word(CFG_QUERY_CLASS, 16'($urandom_range(0, 65535)));
        vary_idle = 1'b0;
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        start = sent;
        while (sent - start < 20)
        begin
            send_name(0, $urandom_range(0, 4) == 0);
        end
        settle();

        if (board.errors == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
